### hw/rtl/rrts_pkg.sv
`default_nettype none

package rrts_pkg;

  localparam int SliceW = 16;
  localparam int IdW = 4;
  localparam logic [SliceW-1:0] SLICE_RESET = 16'd10;
  localparam logic [SliceW-1:0] SLICE_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    KIND_CREATE  = 3'd0,
    KIND_TICK    = 3'd1,
    KIND_YIELD   = 3'd2,
    KIND_BLOCK   = 3'd3,
    KIND_UNBLOCK = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_NO_FREE     = 2'd1,
    STATUS_BLOCK_EMPTY = 2'd2,
    STATUS_NOT_BLOCKED = 2'd3
  } status_t;

  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/round_robin_thread_scheduler.sv
// An accepted event beat passes through the event register and then the result
// register before its result beat can be taken.
// Throughput: one event per cycle; the event register and the result register
// pass a new beat every cycle unless the result side stalls.
// Reset (rst, synchronous, active high): thread 0 runs, the ready queue is
// empty, no thread is blocked, the next id is 1 and the time slice is 10.
`default_nettype none

module round_robin_thread_scheduler #(
  parameter int MAX_THREADS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         event_valid,
  output logic                              event_stall,
  input  wire logic [2:0]                   kind,
  input  wire logic [rrts_pkg::IdW-1:0]     thread_id,
  output logic                              result_valid,
  input  wire logic                         result_stall,
  output logic      [rrts_pkg::IdW-1:0]     running_id,
  output logic                              switched,
  output logic      [rrts_pkg::IdW-1:0]     created_id,
  output logic      [1:0]                   status,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [rrts_pkg::SliceW-1:0]  cfg_data
);

  localparam int IW = $clog2(MAX_THREADS);
  localparam int CW = $clog2(MAX_THREADS + 1);

  logic                        s1_valid;
  logic [2:0]                  s1_kind;
  logic [rrts_pkg::IdW-1:0]    s1_tid;
  logic                        s1_adv;
  logic                        ev_acc;
  logic [rrts_pkg::SliceW-1:0] slice_limit;

  rrts_pkg::queue_ctrl_t       q_ctrl;
  logic [IW-1:0]               q_push_id;
  logic [IW-1:0]               q_pop_id;
  logic [CW-1:0]               q_count;

  logic [rrts_pkg::IdW-1:0]    core_running_id;
  logic                        core_switched;
  logic [rrts_pkg::IdW-1:0]    core_created_id;
  rrts_pkg::status_t           core_status;

  assign s1_adv = s1_valid && (!result_valid || !result_stall);
  assign event_stall = s1_valid && !s1_adv;
  assign ev_acc = event_valid && !event_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_limit <= rrts_pkg::SLICE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      slice_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ev_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_acc) begin
      s1_kind <= kind;
      s1_tid <= thread_id;
    end
  end

  rrts_core #(
    .MAX_THREADS(MAX_THREADS),
    .IW(IW),
    .CW(CW)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .go(s1_adv),
    .kind(s1_kind),
    .tid(s1_tid),
    .slice_limit(slice_limit),
    .q_count(q_count),
    .q_pop_id(q_pop_id),
    .q_ctrl(q_ctrl),
    .q_push_id(q_push_id),
    .running_id(core_running_id),
    .switched(core_switched),
    .created_id(core_created_id),
    .status(core_status)
  );

  rrts_queue #(
    .DEPTH(MAX_THREADS),
    .IW(IW),
    .CW(CW)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .ctrl(q_ctrl),
    .push_id(q_push_id),
    .count(q_count),
    .pop_id(q_pop_id)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      running_id <= core_running_id;
      switched <= core_switched;
      created_id <= core_created_id;
      status <= core_status;
    end
  end

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    (event_valid && !event_stall) |=> s1_valid)
    else $error("accepted event beat did not reach the event register");

  a_advance_gives_result: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> result_valid)
    else $error("processed event produced no result beat");

  a_hold_event: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_kind) && $stable(s1_tid)))
    else $error("held event beat was lost or changed");

  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> (slice_limit == $past(cfg_data)))
    else $error("time slice write was not taken");

endmodule

`default_nettype wire

### hw/rtl/rrts_queue.sv
`default_nettype none

module rrts_queue #(
  parameter int DEPTH = 16,
  parameter int IW = 4,
  parameter int CW = 5
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire rrts_pkg::queue_ctrl_t ctrl,
  input  wire logic [IW-1:0]        push_id,
  output logic      [CW-1:0]        count,
  output logic      [IW-1:0]        pop_id
);

  localparam int SW = CW + 1;

  logic [IW-1:0] ram [DEPTH];
  logic [IW-1:0] front;
  logic [IW-1:0] head;
  logic [IW-1:0] head_next;
  logic [IW-1:0] head_inc;
  logic [IW-1:0] tail;
  logic [SW-1:0] tail_sum;
  logic [CW-1:0] count_next;
  logic          push_ok;

  assign push_ok = ctrl.push && (count < CW'(DEPTH));
  assign tail_sum = SW'(head) + SW'(count);
  assign tail = (tail_sum >= SW'(DEPTH)) ? IW'(tail_sum - SW'(DEPTH)) : IW'(tail_sum);
  assign head_inc = (head == IW'(DEPTH - 1)) ? '0 : head + IW'(1);
  assign head_next = ctrl.pop ? head_inc : head;

  // The front entry is registered ahead of the pop; with nothing queued, the pop
  // takes the entry pushed in the same beat.
  assign pop_id = (count == '0) ? push_id : front;

  always_comb begin
    count_next = count;
    if (push_ok && !ctrl.pop) begin
      count_next = count + CW'(1);
    end else if (!push_ok && ctrl.pop) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      count <= '0;
    end else begin
      head <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      ram[tail] <= push_id;
    end
    if (push_ok && (tail == head_next)) begin
      front <= push_id;
    end else begin
      front <= ram[head_next];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rrts_core.sv
`default_nettype none

module rrts_core #(
  parameter int MAX_THREADS = 16,
  parameter int IW = 4,
  parameter int CW = 5
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         go,
  input  wire logic [2:0]                   kind,
  input  wire logic [rrts_pkg::IdW-1:0]     tid,
  input  wire logic [rrts_pkg::SliceW-1:0]  slice_limit,
  input  wire logic [CW-1:0]                q_count,
  input  wire logic [IW-1:0]                q_pop_id,
  output rrts_pkg::queue_ctrl_t             q_ctrl,
  output logic      [IW-1:0]                q_push_id,
  output logic      [rrts_pkg::IdW-1:0]     running_id,
  output logic                              switched,
  output logic      [rrts_pkg::IdW-1:0]     created_id,
  output rrts_pkg::status_t                 status
);

  localparam int PW = IW + rrts_pkg::IdW;

  logic [IW-1:0]               running;
  logic [IW-1:0]               running_next;
  logic [rrts_pkg::SliceW-1:0] ticks;
  logic [rrts_pkg::SliceW-1:0] ticks_next;
  logic [rrts_pkg::SliceW-1:0] ticks_inc;
  logic [CW-1:0]               next_free;
  logic [CW-1:0]               next_free_next;
  logic [MAX_THREADS-1:0]      blocked;
  logic [MAX_THREADS-1:0]      blocked_next;
  logic [IW-1:0]               created;
  logic [PW-1:0]               tid_pad;
  logic [PW-1:0]               run_pad;
  logic [PW-1:0]               created_pad;
  logic [IW-1:0]               tid_idx;
  logic                        tid_in_range;
  logic                        push;
  logic                        pop;

  assign tid_pad = {{IW{1'b0}}, tid};
  assign tid_in_range = tid_pad < PW'(MAX_THREADS);
  assign tid_idx = tid_pad[IW-1:0];
  assign ticks_inc = (ticks == rrts_pkg::SLICE_MAX) ? ticks : ticks + 16'd1;

  always_comb begin
    running_next = running;
    ticks_next = ticks;
    next_free_next = next_free;
    blocked_next = blocked;
    created = '0;
    status = rrts_pkg::STATUS_OK;
    push = 1'b0;
    pop = 1'b0;
    q_push_id = running;
    case (kind)
      rrts_pkg::KIND_CREATE: begin
        if (next_free >= CW'(MAX_THREADS)) begin
          status = rrts_pkg::STATUS_NO_FREE;
        end else begin
          created = next_free[IW-1:0];
          next_free_next = next_free + CW'(1);
          push = 1'b1;
          q_push_id = next_free[IW-1:0];
        end
      end
      rrts_pkg::KIND_TICK: begin
        ticks_next = ticks_inc;
        if (ticks_inc >= slice_limit) begin
          push = 1'b1;
          pop = 1'b1;
          running_next = q_pop_id;
          ticks_next = '0;
        end
      end
      rrts_pkg::KIND_YIELD: begin
        push = 1'b1;
        pop = 1'b1;
        running_next = q_pop_id;
        ticks_next = '0;
      end
      rrts_pkg::KIND_BLOCK: begin
        if (q_count == '0) begin
          status = rrts_pkg::STATUS_BLOCK_EMPTY;
        end else begin
          blocked_next[running] = 1'b1;
          pop = 1'b1;
          running_next = q_pop_id;
          ticks_next = '0;
        end
      end
      rrts_pkg::KIND_UNBLOCK: begin
        if (!tid_in_range || !blocked[tid_idx]) begin
          status = rrts_pkg::STATUS_NOT_BLOCKED;
        end else begin
          blocked_next[tid_idx] = 1'b0;
          push = 1'b1;
          q_push_id = tid_idx;
        end
      end
      default: begin
      end
    endcase
  end

  assign q_ctrl.push = go && push;
  assign q_ctrl.pop = go && pop;

  assign run_pad = {{rrts_pkg::IdW{1'b0}}, running_next};
  assign created_pad = {{rrts_pkg::IdW{1'b0}}, created};
  assign running_id = run_pad[rrts_pkg::IdW-1:0];
  assign created_id = created_pad[rrts_pkg::IdW-1:0];
  assign switched = running_next != running;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= '0;
      ticks <= '0;
      next_free <= CW'(1);
      blocked <= '0;
    end else if (go) begin
      running <= running_next;
      ticks <= ticks_next;
      next_free <= next_free_next;
      blocked <= blocked_next;
    end
  end

endmodule

`default_nettype wire

### sim/sched_result_checker.sv
`timescale 1ns / 100ps

module sched_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        event_valid,
  input  logic        event_stall,
  input  logic [2:0]  kind,
  input  logic [3:0]  thread_id,
  input  logic        result_valid,
  input  logic        result_stall,
  input  logic [3:0]  running_id,
  input  logic        switched,
  input  logic [3:0]  created_id,
  input  logic [1:0]  status,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          error_count,
  output int          results_due
);

  localparam int NumThreads = 16;

  typedef enum logic [1:0] {
    THR_UNUSED  = 2'd0,
    THR_READY   = 2'd1,
    THR_RUNNING = 2'd2,
    THR_BLOCKED = 2'd3
  } thr_state_t;

  typedef struct packed {
    logic [3:0]        running;
    logic              switched;
    logic [3:0]        created;
    rrts_pkg::status_t status;
  } sched_result_t;

  logic [3:0]    cur_thread;
  logic [15:0]   tick_count;
  logic [15:0]   slice_len;
  logic [4:0]    next_id;
  logic [3:0]    ready_fifo[$];
  thr_state_t    thr_state[NumThreads];
  sched_result_t sched_results_pending[$];

  function automatic void push_ready(input logic [3:0] id);
    if (ready_fifo.size() < NumThreads) begin
      ready_fifo.push_back(id);
    end
  endfunction

  function automatic void run_front();
    cur_thread = ready_fifo.pop_front();
    thr_state[cur_thread] = THR_RUNNING;
    tick_count = '0;
  endfunction

  function automatic void rotate_running();
    thr_state[cur_thread] = THR_READY;
    push_ready(cur_thread);
    run_front();
  endfunction

  function automatic sched_result_t schedule_event(input logic [2:0] k,
                                                   input logic [3:0] tid);
    sched_result_t res;
    logic [3:0] prior;
    prior = cur_thread;
    res.created = '0;
    res.status = rrts_pkg::STATUS_OK;
    case (k)
      rrts_pkg::KIND_CREATE: begin
        if (next_id >= NumThreads) begin
          res.status = rrts_pkg::STATUS_NO_FREE;
        end else begin
          res.created = next_id[3:0];
          thr_state[next_id[3:0]] = THR_READY;
          push_ready(next_id[3:0]);
          next_id = next_id + 5'd1;
        end
      end
      rrts_pkg::KIND_TICK: begin
        if (tick_count != rrts_pkg::SLICE_MAX) begin
          tick_count = tick_count + 16'd1;
        end
        if (tick_count >= slice_len) begin
          rotate_running();
        end
      end
      rrts_pkg::KIND_YIELD: begin
        rotate_running();
      end
      rrts_pkg::KIND_BLOCK: begin
        if (ready_fifo.size() == 0) begin
          res.status = rrts_pkg::STATUS_BLOCK_EMPTY;
        end else begin
          thr_state[cur_thread] = THR_BLOCKED;
          run_front();
        end
      end
      rrts_pkg::KIND_UNBLOCK: begin
        if (thr_state[tid] != THR_BLOCKED) begin
          res.status = rrts_pkg::STATUS_NOT_BLOCKED;
        end else begin
          thr_state[tid] = THR_READY;
          push_ready(tid);
        end
      end
      default: begin
      end
    endcase
    res.running = cur_thread;
    res.switched = (cur_thread != prior);
    return res;
  endfunction

  always @(posedge clk) begin
    sched_result_t want;
    int i;
    if (rst) begin
      error_count = 0;
      cur_thread = '0;
      tick_count = '0;
      slice_len = rrts_pkg::SLICE_RESET;
      next_id = 5'd1;
      ready_fifo.delete();
      sched_results_pending.delete();
      for (i = 0; i < NumThreads; i++) begin
        thr_state[i] = THR_UNUSED;
      end
      thr_state[0] = THR_RUNNING;
    end else begin
      if (cfg_valid && cfg_ready) begin
        slice_len = cfg_data;
      end
      if (result_valid && !result_stall) begin
        if (sched_results_pending.size() == 0) begin
          if (error_count < 10) begin
            $display("%0t: unexpected result: running %0d switched %0d created %0d status %0d",
                     $time, running_id, switched, created_id, status);
          end
          error_count++;
        end else begin
          want = sched_results_pending.pop_front();
          if (running_id !== want.running || switched !== want.switched ||
              created_id !== want.created || status !== want.status) begin
            if (error_count < 10) begin
              $display("%0t: mismatch: expected running %0d switched %0d created %0d status %0d",
                       $time, want.running, want.switched, want.created, want.status);
              $display("%0t: mismatch: got running %0d switched %0d created %0d status %0d",
                       $time, running_id, switched, created_id, status);
            end
            error_count++;
          end
        end
      end
      if (event_valid && !event_stall) begin
        sched_results_pending.push_back(schedule_event(kind, thread_id));
      end
    end
    results_due = sched_results_pending.size();
  end

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

  logic        clk;
  logic        rst;
  logic        event_valid;
  logic        event_stall;
  logic [2:0]  kind;
  logic [3:0]  thread_id;
  logic        result_valid;
  logic        result_stall;
  logic [3:0]  running_id;
  logic        switched;
  logic [3:0]  created_id;
  logic [1:0]  status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  int          error_count;
  int          results_due;
  bit          no_gaps;

  round_robin_thread_scheduler #(
    .MAX_THREADS(16)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .event_valid(event_valid),
    .event_stall(event_stall),
    .kind(kind),
    .thread_id(thread_id),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .running_id(running_id),
    .switched(switched),
    .created_id(created_id),
    .status(status),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  sched_result_checker u_checker (
    .clk(clk),
    .rst(rst),
    .event_valid(event_valid),
    .event_stall(event_stall),
    .kind(kind),
    .thread_id(thread_id),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .running_id(running_id),
    .switched(switched),
    .created_id(created_id),
    .status(status),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .error_count(error_count),
    .results_due(results_due)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("** round_robin_thread_scheduler: FAILED **");
    $finish;
  end

  function automatic int gap_length();
    int r;
    r = $urandom_range(99);
    if (r < 55) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end else begin
      return $urandom_range(8, 40);
    end
  endfunction

  initial begin
    int free_len;
    int stall_len;
    result_stall = 1'b0;
    forever begin
      free_len = $urandom_range(1, 20);
      stall_len = gap_length();
      @(negedge clk) result_stall <= 1'b0;
      repeat (free_len - 1) @(negedge clk);
      if (stall_len > 0) begin
        @(negedge clk) result_stall <= 1'b1;
        repeat (stall_len - 1) @(negedge clk);
      end
    end
  end

  task automatic send_event(input logic [2:0] k, input logic [3:0] tid);
    int gap;
    @(negedge clk);
    event_valid <= 1'b1;
    kind <= k;
    thread_id <= tid;
    do @(posedge clk); while (event_stall);
    gap = no_gaps ? 0 : gap_length();
    if (gap > 0) begin
      @(negedge clk) event_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk) event_valid <= 1'b0;
    wait (results_due == 0);
  endtask

  task automatic write_slice(input logic [15:0] value);
    drain();
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic send_random_event();
    int r;
    logic [2:0] k;
    r = $urandom_range(99);
    if (r < 6) begin
      k = rrts_pkg::KIND_CREATE;
    end else if (r < 40) begin
      k = rrts_pkg::KIND_TICK;
    end else if (r < 55) begin
      k = rrts_pkg::KIND_YIELD;
    end else if (r < 70) begin
      k = rrts_pkg::KIND_BLOCK;
    end else if (r < 94) begin
      k = rrts_pkg::KIND_UNBLOCK;
    end else begin
      k = 3'($urandom_range(5, 7));
    end
    send_event(k, 4'($urandom_range(15)));
  endtask

  initial begin
    logic [15:0] slices[6];
    int p;
    int n;
    rst = 1'b1;
    event_valid = 1'b0;
    kind = '0;
    thread_id = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    no_gaps = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    send_event(rrts_pkg::KIND_YIELD, 4'd0);
    send_event(rrts_pkg::KIND_BLOCK, 4'd15);
    send_event(rrts_pkg::KIND_UNBLOCK, 4'd0);
    send_event(rrts_pkg::KIND_UNBLOCK, 4'd15);
    send_event(3'd7, 4'd15);
    repeat (16) send_event(rrts_pkg::KIND_CREATE, 4'd0);
    send_event(rrts_pkg::KIND_BLOCK, 4'd0);
    send_event(rrts_pkg::KIND_UNBLOCK, 4'd0);
    send_event(rrts_pkg::KIND_UNBLOCK, 4'd0);
    send_event(rrts_pkg::KIND_YIELD, 4'd5);

    slices[0] = 16'd0;
    slices[1] = 16'd1;
    slices[2] = 16'd3;
    slices[3] = 16'hFFFF;
    slices[4] = 16'($urandom_range(2, 40));
    slices[5] = rrts_pkg::SLICE_RESET;
    for (p = 0; p < 6; p++) begin
      write_slice(slices[p]);
      no_gaps = (p == 2);
      for (n = 0; n < 100; n++) begin
        if (p == 4 && n == 50) begin
          drain();
        end
        send_random_event();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (error_count == 0 && results_due == 0) begin
      $display("** round_robin_thread_scheduler: PASSED **");
    end else begin
      $display("** round_robin_thread_scheduler: FAILED **");
    end
    $finish;
  end

endmodule
